>>> design/ped_pkg.sv
// Shared types and constants for the pairwise distance core.
// No dependencies; every other design file but ped_fifo refers to this package by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package ped_pkg;

  localparam int ELEM_W = 16;
  localparam int IDX_W  = 6;
  localparam int DIST_W = 19;
  localparam int CFG_W  = 7;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_NUM_ROWS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_DIMS = 1'b1;

  localparam logic [CFG_W-1:0]  CFG_RESET = 7'd64;
  localparam logic [DIST_W-1:0] DIST_MAX  = 19'd524287;

  // pair identity and end-of-run flags, carried alongside the arithmetic
  typedef struct packed {
    logic [IDX_W-1:0] first_row;
    logic [IDX_W-1:0] second_row;
    logic             run_last;
    logic             matrix_last;
  } ped_tag_t;

  typedef struct packed {
    logic [IDX_W-1:0]  first_row;
    logic [IDX_W-1:0]  second_row;
    logic [DIST_W-1:0] distance;
    logic              run_last;
    logic              matrix_last;
  } ped_result_t;

endpackage

`default_nettype wire

>>> design/ped_fifo.sv
// Small register queue with a count, used for the job queue and the result queue.
// No package dependency.
`timescale 1ns / 1ps
`default_nettype none

module ped_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             wr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd,
  output logic [WIDTH-1:0]      rd_data,
  output logic                  full,
  output logic                  empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_wr;
  logic             do_rd;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_wr   = wr && !full;
  assign do_rd   = rd && !empty;
  assign rd_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

>>> design/ped_front.sv
// Front end: configuration registers, row/column counters, store writes, job issue.
// Uses ped_pkg for field widths and register indexes.
`timescale 1ns / 1ps
`default_nettype none

module ped_front #(
  parameter int MAX_ROWS = 64,
  parameter int MAX_DIMS = 64
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           push,
  output logic                                full,
  input  wire logic signed [ped_pkg::ELEM_W-1:0] element,
  input  wire logic                           cfg_write,
  input  wire logic [ped_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [ped_pkg::CFG_W-1:0]      cfg_data,
  output logic                                mem_we,
  output logic [$clog2(MAX_ROWS*MAX_DIMS)-1:0] mem_waddr,
  output logic [ped_pkg::ELEM_W-1:0]          mem_wdata,
  output logic [$clog2(MAX_DIMS+1)-1:0]       dims_eff,
  output logic                                job_push,
  output logic [$clog2(MAX_ROWS):0]           job_data,
  input  wire logic                           job_full,
  input  wire logic                           job_empty,
  input  wire logic                           eng_busy
);

  localparam int RW  = $clog2(MAX_ROWS);
  localparam int DW  = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
  localparam int AW  = $clog2(MAX_ROWS * MAX_DIMS);
  localparam int RCW = $clog2(MAX_ROWS + 1);
  localparam int DCW = $clog2(MAX_DIMS + 1);

  logic [ped_pkg::CFG_W-1:0] num_rows;
  logic [ped_pkg::CFG_W-1:0] num_dims;
  logic [RW-1:0]             row_count;
  logic [DW-1:0]             dim_count;
  logic [RW-1:0]             last_j;
  logic [RCW-1:0]            rows_eff;
  logic                      accept;
  logic                      row_done;
  logic                      row_wrap;
  logic                      hazard;

  always_comb begin
    if (num_rows < 7'd2) begin
      rows_eff = RCW'(2);
    end else if (int'(num_rows) > MAX_ROWS) begin
      rows_eff = RCW'(MAX_ROWS);
    end else begin
      rows_eff = RCW'(num_rows);
    end
    if (num_dims == '0) begin
      dims_eff = DCW'(1);
    end else if (int'(num_dims) > MAX_DIMS) begin
      dims_eff = DCW'(MAX_DIMS);
    end else begin
      dims_eff = DCW'(num_dims);
    end
  end

  // the engine reads rows 0..j of every queued job; hold off writes into them
  assign hazard   = (!job_empty || eng_busy) && (last_j >= row_count);
  assign full     = hazard || job_full;
  assign accept   = push && !full;
  assign row_done = (int'(dim_count) + 1) >= int'(dims_eff);
  assign row_wrap = (int'(row_count) + 1) >= int'(rows_eff);

  assign mem_we    = accept;
  assign mem_waddr = AW'(int'(row_count) * MAX_DIMS + int'(dim_count));
  assign mem_wdata = element;
  assign job_push  = accept && row_done && (row_count != '0);
  assign job_data  = {row_wrap, row_count};

  always_ff @(posedge clk) begin
    if (rst) begin
      num_rows  <= ped_pkg::CFG_RESET;
      num_dims  <= ped_pkg::CFG_RESET;
      row_count <= '0;
      dim_count <= '0;
      last_j    <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        ped_pkg::CFG_NUM_ROWS: num_rows <= cfg_data;
        ped_pkg::CFG_NUM_DIMS: num_dims <= cfg_data;
        default: ;
      endcase
      row_count <= '0;
      dim_count <= '0;
    end else if (accept) begin
      if (row_done) begin
        dim_count <= '0;
        last_j    <= row_count;
        row_count <= row_wrap ? '0 : row_count + 1'b1;
      end else begin
        dim_count <= dim_count + 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

>>> design/ped_engine.sv
// Back end: vector store, pair/column sequencer and the squared-difference accumulator.
// Uses ped_pkg for the tag type; hands finished sums to ped_sqrt.
`timescale 1ns / 1ps
`default_nettype none

module ped_engine #(
  parameter int MAX_ROWS = 64,
  parameter int MAX_DIMS = 64
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              mem_we,
  input  wire logic [$clog2(MAX_ROWS*MAX_DIMS)-1:0] mem_waddr,
  input  wire logic [ped_pkg::ELEM_W-1:0]        mem_wdata,
  input  wire logic [$clog2(MAX_DIMS+1)-1:0]     dims_eff,
  input  wire logic                              job_empty,
  input  wire logic [$clog2(MAX_ROWS):0]         job_data,
  output logic                                   job_pop,
  output logic                                   busy,
  output logic                                   sum_valid,
  output logic [((32+$clog2(MAX_DIMS)+1)/2)*2-1:0] sum,
  output ped_pkg::ped_tag_t                      sum_tag,
  input  wire logic                              sum_take
);

  localparam int RW  = $clog2(MAX_ROWS);
  localparam int DW  = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
  localparam int AW  = $clog2(MAX_ROWS * MAX_DIMS);
  localparam int SW  = 32 + $clog2(MAX_DIMS);
  localparam int SQW = ((SW + 1) / 2) * 2;

  logic [ped_pkg::ELEM_W-1:0] store [MAX_ROWS * MAX_DIMS];

  // sequencer
  logic          active;
  logic [RW-1:0] cur_j;
  logic [RW-1:0] cur_i;
  logic [DW-1:0] cur_k;
  logic          cur_mlast;
  logic          k_last;
  logic          adv;
  logic [AW-1:0] addr_a;
  logic [AW-1:0] addr_b;
  ped_pkg::ped_tag_t cur_tag;

  // pipeline: read data, square, accumulate
  logic signed [ped_pkg::ELEM_W-1:0] rd_a;
  logic signed [ped_pkg::ELEM_W-1:0] rd_b;
  logic              v1, f1, l1;
  ped_pkg::ped_tag_t t1;
  logic signed [ped_pkg::ELEM_W:0]   diff;
  logic signed [2*ped_pkg::ELEM_W+1:0] prod;
  logic [31:0]       sq;
  logic              v2, f2, l2;
  ped_pkg::ped_tag_t t2;
  logic [SW-1:0]     acc;
  logic [SW-1:0]     acc_next;

  assign adv     = !sum_valid || sum_take;
  assign busy    = active;
  assign job_pop = !active && !job_empty;
  assign k_last  = (int'(cur_k) + 1) >= int'(dims_eff);
  assign addr_a  = AW'(int'(cur_j) * MAX_DIMS + int'(cur_k));
  assign addr_b  = AW'(int'(cur_i) * MAX_DIMS + int'(cur_k));

  always_comb begin
    cur_tag.first_row   = ped_pkg::IDX_W'(cur_i);
    cur_tag.second_row  = ped_pkg::IDX_W'(cur_j);
    cur_tag.run_last    = (int'(cur_i) + 1) == int'(cur_j);
    cur_tag.matrix_last = cur_tag.run_last && cur_mlast;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      store[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && active) begin
      rd_a <= store[addr_a];
      rd_b <= store[addr_b];
      f1   <= (cur_k == '0);
      l1   <= k_last;
      t1   <= cur_tag;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= 1'b0;
      cur_j     <= '0;
      cur_i     <= '0;
      cur_k     <= '0;
      cur_mlast <= 1'b0;
    end else if (job_pop) begin
      active    <= 1'b1;
      cur_j     <= job_data[RW-1:0];
      cur_mlast <= job_data[RW];
      cur_i     <= '0;
      cur_k     <= '0;
    end else if (adv && active) begin
      if (k_last) begin
        cur_k <= '0;
        if ((int'(cur_i) + 1) == int'(cur_j)) begin
          active <= 1'b0;
        end else begin
          cur_i <= cur_i + 1'b1;
        end
      end else begin
        cur_k <= cur_k + 1'b1;
      end
    end
  end

  assign diff     = {rd_a[ped_pkg::ELEM_W-1], rd_a} - {rd_b[ped_pkg::ELEM_W-1], rd_b};
  assign prod     = diff * diff;
  assign acc_next = (f2 ? '0 : acc) + SW'(sq);

  always_ff @(posedge clk) begin
    if (adv) begin
      sq <= prod[31:0];
      f2 <= f1;
      l2 <= l1;
      t2 <= t1;
      if (v2) begin
        acc <= acc_next;
      end
      if (v2 && l2) begin
        sum     <= SQW'(acc_next);
        sum_tag <= t2;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      sum_valid <= 1'b0;
    end else begin
      if (adv) begin
        v1 <= active && !job_pop;
        v2 <= v1;
      end
      if (adv && v2 && l2) begin
        sum_valid <= 1'b1;
      end else if (sum_take) begin
        sum_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

>>> design/ped_sqrt.sv
// Iterative integer square root, one result bit per cycle, with saturation to 19 bits.
// Uses ped_pkg for the tag and result types.
`timescale 1ns / 1ps
`default_nettype none

module ped_sqrt #(
  parameter int IN_W = 38
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [IN_W-1:0]   in_sum,
  input  wire ped_pkg::ped_tag_t in_tag,
  output logic                   out_push,
  input  wire logic              out_full,
  output ped_pkg::ped_result_t   out_data
);

  localparam int H   = IN_W / 2;
  localparam int RMW = H + 1;
  localparam int CNW = $clog2(H);
  localparam int CW  = (H > ped_pkg::DIST_W) ? H : ped_pkg::DIST_W;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RUN  = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0]        state;
  logic [IN_W-1:0]   val;
  logic [RMW-1:0]    rem;
  logic [H-1:0]      root;
  logic [CNW-1:0]    cnt;
  ped_pkg::ped_tag_t tag;
  logic [H+2:0]      sh;
  logic [H+2:0]      trial;
  logic              ge;
  logic [CW-1:0]     root_w;

  assign in_ready = (state == S_IDLE);
  assign out_push = (state == S_DONE) && !out_full;

  // bring down the next two bits and try root*4+1
  assign sh     = {rem, val[IN_W-1 -: 2]};
  assign trial  = {1'b0, root, 2'b01};
  assign ge     = sh >= trial;
  assign root_w = CW'(root);

  always_comb begin
    out_data.first_row   = tag.first_row;
    out_data.second_row  = tag.second_row;
    out_data.run_last    = tag.run_last;
    out_data.matrix_last = tag.matrix_last;
    out_data.distance    = (root_w > CW'(ped_pkg::DIST_MAX)) ?
                           ped_pkg::DIST_MAX : root_w[ped_pkg::DIST_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      val  <= in_sum;
      rem  <= '0;
      root <= '0;
      tag  <= in_tag;
    end else if (state == S_RUN) begin
      val  <= val << 2;
      rem  <= ge ? RMW'(sh - trial) : RMW'(sh);
      root <= {root[H-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_RUN;
            cnt   <= CNW'(H - 1);
          end
        end
        S_RUN: begin
          if (cnt == '0) begin
            state <= S_DONE;
          end else begin
            cnt <= cnt - 1'b1;
          end
        end
        S_DONE: begin
          if (!out_full) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> design/pairwise_euclidean_distance_core.sv
// The element completing row j pushes a job; its distances pass through the job queue, the engine's
// store read, square and accumulate registers, and the square-root unit, which takes one pair at a
// time. Row j's pairs share the single multiply-accumulate and the two store read ports. Reset (rst,
// synchronous): counters and queues clear, both registers return to 64. The vector store is not
// cleared; only rows of the current matrix are read.
// Depends on ped_pkg, ped_front, ped_fifo, ped_engine and ped_sqrt.
`timescale 1ns / 1ps
`default_nettype none

module pairwise_euclidean_distance_core #(
  parameter int MAX_ROWS = 64,
  parameter int MAX_DIMS = 64
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              push,
  output logic                                   full,
  input  wire logic signed [ped_pkg::ELEM_W-1:0] element,
  output logic                                   empty,
  input  wire logic                              pop,
  output logic [ped_pkg::IDX_W-1:0]              first_row,
  output logic [ped_pkg::IDX_W-1:0]              second_row,
  output logic [ped_pkg::DIST_W-1:0]             distance,
  output logic                                   run_last,
  output logic                                   matrix_last,
  input  wire logic                              cfg_write,
  input  wire logic [ped_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [ped_pkg::CFG_W-1:0]         cfg_data
);

  localparam int RW  = $clog2(MAX_ROWS);
  localparam int AW  = $clog2(MAX_ROWS * MAX_DIMS);
  localparam int DCW = $clog2(MAX_DIMS + 1);
  localparam int SW  = 32 + $clog2(MAX_DIMS);
  localparam int SQW = ((SW + 1) / 2) * 2;
  localparam int RES_W = $bits(ped_pkg::ped_result_t);

  logic                       mem_we;
  logic [AW-1:0]              mem_waddr;
  logic [ped_pkg::ELEM_W-1:0] mem_wdata;
  logic [DCW-1:0]             dims_eff;
  logic                       job_push;
  logic [RW:0]                job_wdata;
  logic [RW:0]                job_rdata;
  logic                       job_pop;
  logic                       job_full;
  logic                       job_empty;
  logic                       eng_busy;
  logic                       sum_valid;
  logic [SQW-1:0]             sum;
  ped_pkg::ped_tag_t          sum_tag;
  logic                       sqrt_ready;
  logic                       res_push;
  logic                       res_full;
  ped_pkg::ped_result_t       res_in;
  logic [RES_W-1:0]           res_q;
  ped_pkg::ped_result_t       res_out;

  ped_front #(.MAX_ROWS(MAX_ROWS), .MAX_DIMS(MAX_DIMS)) u_front (
    .clk, .rst, .push, .full, .element, .cfg_write, .cfg_index, .cfg_data,
    .mem_we, .mem_waddr, .mem_wdata, .dims_eff,
    .job_push, .job_data(job_wdata), .job_full, .job_empty, .eng_busy
  );

  ped_fifo #(.WIDTH(RW + 1), .DEPTH(2)) u_job_q (
    .clk, .rst, .wr(job_push), .wr_data(job_wdata), .rd(job_pop),
    .rd_data(job_rdata), .full(job_full), .empty(job_empty)
  );

  ped_engine #(.MAX_ROWS(MAX_ROWS), .MAX_DIMS(MAX_DIMS)) u_engine (
    .clk, .rst, .mem_we, .mem_waddr, .mem_wdata, .dims_eff,
    .job_empty, .job_data(job_rdata), .job_pop, .busy(eng_busy),
    .sum_valid, .sum, .sum_tag, .sum_take(sum_valid && sqrt_ready)
  );

  ped_sqrt #(.IN_W(SQW)) u_sqrt (
    .clk, .rst, .in_valid(sum_valid), .in_ready(sqrt_ready), .in_sum(sum),
    .in_tag(sum_tag), .out_push(res_push), .out_full(res_full), .out_data(res_in)
  );

  ped_fifo #(.WIDTH(RES_W), .DEPTH(4)) u_res_q (
    .clk, .rst, .wr(res_push), .wr_data(res_in), .rd(pop),
    .rd_data(res_q), .full(res_full), .empty
  );

  assign res_out     = res_q;
  assign first_row   = res_out.first_row;
  assign second_row  = res_out.second_row;
  assign distance    = res_out.distance;
  assign run_last    = res_out.run_last;
  assign matrix_last = res_out.matrix_last;

  // a completed row never enters a full job queue
  a_job_no_overflow: assert property (@(posedge clk) disable iff (rst)
    job_push |-> !job_full)
    else $error("job queue overflow");

  // the root unit only finishes into a free result slot
  a_res_no_overflow: assert property (@(posedge clk) disable iff (rst)
    res_push |-> !res_full)
    else $error("result queue overflow");

  // the end of a matrix is always the end of a run
  a_last_flags: assert property (@(posedge clk) disable iff (rst)
    (!empty && matrix_last) |-> run_last)
    else $error("matrix_last without run_last");

  // a popped job always starts the sequencer
  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    job_pop |=> eng_busy)
    else $error("job popped without engine start");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> empty)
    else $error("results present after reset");

endmodule

`default_nettype wire

>>> tb/tb.sv
// Self-checking bench for pairwise_euclidean_distance_core: directed table then random matrices.
// Depends on ped_pkg and the core; expected distances come from a local predictor in this file or the directed table.
`timescale 1ns / 1ps

module tb;

  localparam int MAX_ROWS   = 64;
  localparam int MAX_DIMS   = 64;
  localparam int STALL_MAX  = 20000;
  localparam int SETTLE_CYC = 150;
  localparam int HOLD_CYC   = 3000;

  typedef enum logic [1:0] {KIND_CFG, KIND_QUIET, KIND_ONE, KIND_MODEL} stim_kind_t;

  typedef struct {
    stim_kind_t                    kind;
    logic [ped_pkg::CFG_IDX_W-1:0] reg_sel;
    logic [ped_pkg::ELEM_W-1:0]    value;
    ped_pkg::ped_result_t          want;
  } stim_row_t;

  logic                              clk = 1'b0;
  logic                              rst = 1'b1;
  logic                              push = 1'b0;
  logic signed [ped_pkg::ELEM_W-1:0] element = '0;
  logic                              pop = 1'b0;
  logic                              cfg_write = 1'b0;
  logic [ped_pkg::CFG_IDX_W-1:0]     cfg_index = '0;
  logic [ped_pkg::CFG_W-1:0]         cfg_data = '0;
  logic                              full, empty, run_last, matrix_last;
  logic [ped_pkg::IDX_W-1:0]         first_row, second_row;
  logic [ped_pkg::DIST_W-1:0]        distance;

  // predictor state
  logic [ped_pkg::ELEM_W-1:0] row_mem [MAX_ROWS*MAX_DIMS];
  logic [ped_pkg::CFG_W-1:0]  rows_cfg, dims_cfg;
  int                         row_pos, col_pos;

  ped_pkg::ped_result_t pending_dists [$];
  ped_pkg::ped_result_t fresh_dists [$];
  stim_row_t            stim_tab [$];

  int  err_cnt = 0;
  int  send_idle = 36;
  int  recv_idle = 47;
  bit  hold_req = 1'b0;
  int  hold_left = 0;
  bit  rst_done = 1'b0;
  int  stall_cycles = 0;

  pairwise_euclidean_distance_core #(
    .MAX_ROWS(MAX_ROWS),
    .MAX_DIMS(MAX_DIMS)
  ) u_top (
    .clk(clk), .rst(rst),
    .push(push), .full(full), .element(element),
    .empty(empty), .pop(pop),
    .first_row(first_row), .second_row(second_row), .distance(distance),
    .run_last(run_last), .matrix_last(matrix_last),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  task automatic note_error(input string what);
    err_cnt++;
    if (err_cnt <= 10) $display("%0t: %s", $realtime, what);
  endtask

  // Works out the distances that one accepted element causes, into fresh_dists.
  task automatic compute_distances(input logic [ped_pkg::ELEM_W-1:0] elem);
    int                   rows, dims;
    longint signed        diff;
    longint unsigned      acc, root, trial;
    ped_pkg::ped_result_t r;
    rows = (rows_cfg < 2) ? 2 : (rows_cfg > MAX_ROWS) ? MAX_ROWS : int'(rows_cfg);
    dims = (dims_cfg < 1) ? 1 : (dims_cfg > MAX_DIMS) ? MAX_DIMS : int'(dims_cfg);
    fresh_dists.delete();
    if (row_pos >= rows) row_pos = 0;
    if (col_pos >= dims) col_pos = 0;
    row_mem[row_pos*MAX_DIMS + col_pos] = elem;
    if (col_pos + 1 < dims) begin
      col_pos++;
      return;
    end
    for (int i = 0; i < row_pos; i++) begin
      acc = 0;
      for (int k = 0; k < dims; k++) begin
        diff = longint'(signed'(row_mem[row_pos*MAX_DIMS + k]))
             - longint'(signed'(row_mem[i*MAX_DIMS + k]));
        acc += longint'(diff * diff);
      end
      // bitwise floor square root, top bit first
      root = 0;
      for (int b = 20; b >= 0; b--) begin
        trial = root | (64'd1 << b);
        if (trial * trial <= acc) root = trial;
      end
      if (root > ped_pkg::DIST_MAX) root = ped_pkg::DIST_MAX;
      r.first_row   = ped_pkg::IDX_W'(i);
      r.second_row  = ped_pkg::IDX_W'(row_pos);
      r.distance    = root[ped_pkg::DIST_W-1:0];
      r.run_last    = (i + 1 == row_pos);
      r.matrix_last = (i + 1 == row_pos) && (row_pos + 1 == rows);
      fresh_dists.push_back(r);
    end
    col_pos = 0;
    row_pos = (row_pos + 1 >= rows) ? 0 : row_pos + 1;
  endtask

  task automatic send_item(input logic [ped_pkg::ELEM_W-1:0] v);
    while ($urandom_range(0, 99) < send_idle) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push    <= 1'b1;
    element <= v;
    do @(posedge clk); while (full);
  endtask

  task automatic drain();
    push <= 1'b0;
    @(posedge clk);
    while (pending_dists.size() != 0) @(posedge clk);
  endtask

  // block may still be busy with a partial row after the last distance
  task automatic settle();
    drain();
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic write_reg(input logic [ped_pkg::CFG_IDX_W-1:0] idx,
                           input logic [ped_pkg::CFG_W-1:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    if (idx == ped_pkg::CFG_NUM_ROWS) rows_cfg = val;
    else dims_cfg = val;
    row_pos = 0;
    col_pos = 0;
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  task automatic add_cfg(input logic [ped_pkg::CFG_IDX_W-1:0] idx,
                         input logic [ped_pkg::CFG_W-1:0] val);
    stim_row_t r;
    r.kind    = KIND_CFG;
    r.reg_sel = idx;
    r.value   = ped_pkg::ELEM_W'(val);
    r.want    = '0;
    stim_tab.push_back(r);
  endtask

  // typed results are always the pair (0,1) closing a row
  task automatic add_item(input stim_kind_t kind, input logic [ped_pkg::ELEM_W-1:0] v,
                          input logic [ped_pkg::DIST_W-1:0] want_dist, input logic mlast);
    stim_row_t r;
    r.kind             = kind;
    r.reg_sel          = '0;
    r.value            = v;
    r.want.first_row   = 6'd0;
    r.want.second_row  = 6'd1;
    r.want.distance    = want_dist;
    r.want.run_last    = 1'b1;
    r.want.matrix_last = mlast;
    stim_tab.push_back(r);
  endtask

  task automatic random_block(input logic [ped_pkg::CFG_W-1:0] rows_raw,
                              input logic [ped_pkg::CFG_W-1:0] dims_raw,
                              input int n_items, input bit mid_drain, input bit hold);
    logic [ped_pkg::ELEM_W-1:0] v;
    settle();
    write_reg(ped_pkg::CFG_NUM_ROWS, rows_raw);
    write_reg(ped_pkg::CFG_NUM_DIMS, dims_raw);
    if (hold) hold_req = 1'b1;
    for (int n = 0; n < n_items; n++) begin
      if (mid_drain && n == n_items / 2) drain();
      case ($urandom_range(0, 7))
        0: v = 16'h8000;
        1: v = 16'h7fff;
        2: v = ped_pkg::ELEM_W'($urandom_range(0, 15)) - 16'd8;
        default: v = ped_pkg::ELEM_W'($urandom);
      endcase
      send_item(v);
      compute_distances(v);
      foreach (fresh_dists[i]) pending_dists.push_back(fresh_dists[i]);
    end
  endtask

  // result side: check the beat, then decide next pop
  initial begin
    ped_pkg::ped_result_t want;
    wait (rst_done);
    forever begin
      @(posedge clk);
      if (pop && !empty) begin
        if (pending_dists.size() == 0) begin
          note_error($sformatf("unexpected beat (%0d,%0d) dist %0d rl %0b ml %0b",
                               first_row, second_row, distance, run_last, matrix_last));
        end else begin
          want = pending_dists.pop_front();
          if (first_row !== want.first_row || second_row !== want.second_row ||
              distance !== want.distance || run_last !== want.run_last ||
              matrix_last !== want.matrix_last)
            note_error({$sformatf("exp (%0d,%0d) dist %0d rl %0b ml %0b,",
                                  want.first_row, want.second_row, want.distance,
                                  want.run_last, want.matrix_last),
                        $sformatf(" got (%0d,%0d) dist %0d rl %0b ml %0b",
                                  first_row, second_row, distance, run_last,
                                  matrix_last)});
        end
      end
      if (hold_req) begin
        hold_left = HOLD_CYC;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) hold_left--;
      pop <= (hold_left == 0) && ($urandom_range(0, 99) >= recv_idle);
    end
  end

  // watchdog on cycles with no beat on any port
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty) || cfg_write) stall_cycles = 0;
    else stall_cycles++;
    if (stall_cycles >= STALL_MAX) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    rows_cfg = ped_pkg::CFG_RESET;
    dims_cfg = ped_pkg::CFG_RESET;
    row_pos  = 0;
    col_pos  = 0;
    foreach (row_mem[i]) row_mem[i] = '0;

    // directed: extremes, clamped register values, first row, restart mid-row
    add_cfg(ped_pkg::CFG_NUM_ROWS, 7'd2);
    add_cfg(ped_pkg::CFG_NUM_DIMS, 7'd1);
    add_item(KIND_QUIET, 16'h7fff, 19'd0, 1'b0);
    add_item(KIND_ONE, 16'h8000, 19'd65535, 1'b1);
    add_item(KIND_QUIET, 16'h0000, 19'd0, 1'b0);
    add_item(KIND_ONE, 16'h0000, 19'd0, 1'b1);
    add_item(KIND_QUIET, 16'h8000, 19'd0, 1'b0);
    add_item(KIND_ONE, 16'h7fff, 19'd65535, 1'b1);
    add_item(KIND_QUIET, 16'hffff, 19'd0, 1'b0);
    add_item(KIND_ONE, 16'h0000, 19'd1, 1'b1);
    add_cfg(ped_pkg::CFG_NUM_DIMS, 7'd0);
    add_item(KIND_QUIET, 16'd5, 19'd0, 1'b0);
    add_item(KIND_ONE, -16'sd3, 19'd8, 1'b1);
    add_cfg(ped_pkg::CFG_NUM_ROWS, 7'd0);
    add_cfg(ped_pkg::CFG_NUM_DIMS, 7'd2);
    add_item(KIND_QUIET, 16'd3, 19'd0, 1'b0);
    add_item(KIND_QUIET, 16'd4, 19'd0, 1'b0);
    add_item(KIND_QUIET, 16'd0, 19'd0, 1'b0);
    add_item(KIND_ONE, 16'd0, 19'd5, 1'b1);
    add_cfg(ped_pkg::CFG_NUM_ROWS, 7'd1);
    add_cfg(ped_pkg::CFG_NUM_DIMS, 7'd1);
    add_item(KIND_QUIET, 16'd100, 19'd0, 1'b0);
    add_item(KIND_ONE, -16'sd100, 19'd200, 1'b1);
    add_cfg(ped_pkg::CFG_NUM_ROWS, 7'd3);
    add_item(KIND_QUIET, 16'd1, 19'd0, 1'b0);
    add_item(KIND_ONE, 16'd2, 19'd1, 1'b0);
    add_item(KIND_MODEL, 16'd4, 19'd0, 1'b0);
    add_cfg(ped_pkg::CFG_NUM_DIMS, 7'd2);
    add_item(KIND_MODEL, 16'd7, 19'd0, 1'b0);
    add_cfg(ped_pkg::CFG_NUM_DIMS, 7'd2);
    add_item(KIND_MODEL, -16'sd9, 19'd0, 1'b0);
    add_item(KIND_MODEL, 16'd11, 19'd0, 1'b0);
    add_item(KIND_MODEL, 16'd12, 19'd0, 1'b0);
    add_item(KIND_MODEL, 16'd13, 19'd0, 1'b0);

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    rst_done = 1'b1;
    @(posedge clk);

    foreach (stim_tab[t]) begin
      if (stim_tab[t].kind == KIND_CFG) begin
        settle();
        write_reg(stim_tab[t].reg_sel, stim_tab[t].value[ped_pkg::CFG_W-1:0]);
      end else begin
        send_item(stim_tab[t].value);
        compute_distances(stim_tab[t].value);
        if (stim_tab[t].kind == KIND_ONE) pending_dists.push_back(stim_tab[t].want);
        else if (stim_tab[t].kind == KIND_MODEL)
          foreach (fresh_dists[i]) pending_dists.push_back(fresh_dists[i]);
      end
    end

    random_block(7'd4, 7'd3, 30, 1'b0, 1'b0);
    random_block(7'd127, 7'd1, 66, 1'b1, 1'b0);

    send_idle = 47;
    recv_idle = 36;
    random_block(7'd2, 7'd127, 130, 1'b1, 1'b0);
    random_block(7'd5, 7'd2, 20, 1'b0, 1'b0);

    send_idle = 0;
    recv_idle = 0;
    // receiver holds off while elements keep coming, so the core backs up
    random_block(7'd10, 7'd1, 50, 1'b0, 1'b1);
    random_block(7'd7, 7'd5, 20, 1'b1, 1'b0);

    drain();
    repeat (SETTLE_CYC) @(posedge clk);
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

>>> files.f
design/ped_pkg.sv
design/ped_fifo.sv
design/ped_front.sv
design/ped_engine.sv
design/ped_sqrt.sv
design/pairwise_euclidean_distance_core.sv
tb/tb.sv
